FILE: design/emvtlv_pkg.sv
`timescale 1ns / 1ps

package emvtlv_pkg;

    localparam int TAG_W        = 24;
    localparam int LEN_W        = 16;
    localparam int CFG_W        = 8;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int OUT_TDATA_W  = 64;
    localparam int OUT_TUSER_W  = 4;

    localparam int TAG_BYTES_MAX = 3;
    localparam int LEN_BYTES_MAX = 2;

    localparam logic [TAG_W-1:0]  TAG_PAN    = 24'h00005A;
    localparam logic [TAG_W-1:0]  TAG_ISSUER = 24'h000042;
    localparam logic [TAG_W-1:0]  TAG_NAME   = 24'h005F20;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;

    localparam logic [CFG_IDX_W-1:0] CFG_PAN_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_MAX = 2'd3;

    typedef enum logic [2:0] {
        PH_TAG = 3'b001,
        PH_LEN = 3'b010,
        PH_VAL = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_TAG  = 2'd0,
        ROLE_LEN  = 2'd1,
        ROLE_VAL  = 2'd2,
        ROLE_SKIP = 2'd3
    } role_t;

    typedef enum logic [1:0] {
        KIND_GENERIC = 2'd0,
        KIND_PAN     = 2'd1,
        KIND_ISSUER  = 2'd2,
        KIND_NAME    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_LONG_LEN  = 3'd2,
        ST_NON_DIGIT = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_BAD_CHAR  = 3'd5,
        ST_TRUNC     = 3'd6
    } status_t;

    typedef struct packed {
        phase_t           phase;
        logic [TAG_W-1:0] tag;
        logic [1:0]       tag_cnt;
        logic [LEN_W-1:0] len;
        logic [1:0]       len_left;
        logic [LEN_W-1:0] val_cnt;
        kind_t            kind;
        logic             digit_err;
        logic             char_err;
        logic             skip;
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] pan_min;
        logic [CFG_W-1:0] pan_max;
        logic [CFG_W-1:0] name_min;
        logic [CFG_W-1:0] name_max;
    } cfg_t;

    typedef struct packed {
        role_t            role;
        logic [TAG_W-1:0] tag;
        logic             known;
        kind_t            kind;
        logic [LEN_W-1:0] vlen;
        logic [LEN_W-1:0] vidx;
        logic             done;
        status_t          status;
        logic             last;
    } result_t;

    localparam state_t STATE_CLEAR = '{PH_TAG, 24'h0, 2'd0, 16'h0, 2'd0, 16'h0,
                                       KIND_GENERIC, 1'b0, 1'b0, 1'b0};

    localparam cfg_t CFG_RESET = '{8'd4, 8'd10, 8'd2, 8'd26};

    function automatic logic tag_in_table(input logic [TAG_W-1:0] t);
        return t inside {
            24'h9F26, 24'h9F42, 24'h9F44, 24'h9F05, 24'h5F25, 24'h5F24, 24'h94,
            24'h4F, 24'h82, 24'h50, 24'h9F12, 24'h5A, 24'h5F34, 24'h87, 24'h9F3B,
            24'h9F43, 24'h61, 24'h9F36, 24'h9F07, 24'h9F08, 24'h5F54, 24'h8C,
            24'h8D, 24'h5F20, 24'h9F0B, 24'h8E, 24'h8F, 24'h9F27, 24'h9F45,
            24'h84, 24'h9D, 24'h73, 24'h9F49, 24'hBF0C, 24'hA5, 24'h6F, 24'h9F4C,
            24'h9F2D, 24'h9F2E, 24'h9F2F, 24'h9F46, 24'h9F47, 24'h9F48, 24'h5F53,
            24'h9F0D, 24'h9F0E, 24'h9F0F, 24'h9F10, 24'h9F11, 24'h5F28, 24'h5F55,
            24'h5F56, 24'h42, 24'h90, 24'h9F32, 24'h92, 24'h5F50, 24'h5F2D,
            24'h9F13, 24'h9F4D, 24'h9F4F, 24'h9F14, 24'h9F17, 24'h9F38, 24'h70,
            24'h80, 24'h77, 24'h5F30, 24'h88, 24'h9F4B, 24'h93, 24'h9F4A,
            24'h9F1F, 24'h9F20, 24'h57, 24'h97, 24'h9F23
        };
    endfunction

    function automatic kind_t kind_of(input logic [TAG_W-1:0] t);
        kind_t k;
        k = KIND_GENERIC;
        if (t == TAG_PAN) begin
            k = KIND_PAN;
        end else if (t == TAG_ISSUER) begin
            k = KIND_ISSUER;
        end else if (t == TAG_NAME) begin
            k = KIND_NAME;
        end
        return k;
    endfunction

    function automatic logic is_bcd(input logic [BYTE_W-1:0] b);
        return (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
    endfunction

    function automatic status_t elem_status(input kind_t kind, input logic [LEN_W-1:0] len,
                                            input logic digit_err, input logic char_err,
                                            input cfg_t cfg);
        status_t st;
        st = ST_OK;
        case (kind)
            KIND_PAN: begin
                if (digit_err) begin
                    st = ST_NON_DIGIT;
                end else if (len < LEN_W'(cfg.pan_min) || len > LEN_W'(cfg.pan_max)) begin
                    st = ST_BAD_LEN;
                end
            end
            KIND_ISSUER: begin
                if (digit_err) begin
                    st = ST_NON_DIGIT;
                end
            end
            KIND_NAME: begin
                if (len < LEN_W'(cfg.name_min) || len > LEN_W'(cfg.name_max)) begin
                    st = ST_BAD_LEN;
                end else if (char_err) begin
                    st = ST_BAD_CHAR;
                end
            end
            default: st = ST_OK;
        endcase
        return st;
    endfunction

endpackage

FILE: design/emvtlv_step.sv
`timescale 1ns / 1ps

module emvtlv_step (
    input  emvtlv_pkg::state_t           cur,
    input  emvtlv_pkg::cfg_t             cfg,
    input  logic [emvtlv_pkg::BYTE_W-1:0] data_byte,
    input  logic                         eor,
    output emvtlv_pkg::state_t           nxt,
    output emvtlv_pkg::result_t          res
);
    import emvtlv_pkg::*;

    logic             pending;
    logic             finished;
    logic             more;
    logic             skip_keep;
    logic [TAG_W-1:0] tag_new;
    logic [1:0]       cnt_new;
    logic [6:0]       n_bytes;
    logic [LEN_W:0]   cnt_ext;

    always_comb begin
        nxt       = cur;
        res       = '0;
        res.last  = eor;
        pending   = 1'b0;
        finished  = 1'b0;
        more      = 1'b0;
        skip_keep = 1'b0;
        tag_new   = {cur.tag[TAG_W-9:0], data_byte};
        cnt_new   = cur.tag_cnt + 2'd1;
        n_bytes   = data_byte[6:0];
        cnt_ext   = {1'b0, cur.val_cnt} + (LEN_W+1)'(1);

        if (cur.skip) begin
            res.role = ROLE_SKIP;
        end else begin
            case (cur.phase)
                PH_TAG: begin
                    res.role    = ROLE_TAG;
                    nxt.tag     = tag_new;
                    nxt.tag_cnt = cnt_new;
                    res.tag     = tag_new;
                    more = (cur.tag_cnt == 2'd0) ? (&data_byte[4:0]) : data_byte[7];
                    if (more) begin
                        if (cnt_new >= 2'(TAG_BYTES_MAX)) begin
                            res.status = ST_UNKNOWN;
                            nxt.skip   = 1'b1;
                        end else begin
                            pending = 1'b1;
                        end
                    end else if (tag_in_table(tag_new)) begin
                        res.known = 1'b1;
                        nxt.kind  = kind_of(tag_new);
                        res.kind  = kind_of(tag_new);
                        nxt.phase = PH_LEN;
                        pending   = 1'b1;
                    end else begin
                        res.status = ST_UNKNOWN;
                        nxt.skip   = 1'b1;
                    end
                end
                PH_LEN: begin
                    res.role  = ROLE_LEN;
                    res.tag   = cur.tag;
                    res.known = 1'b1;
                    res.kind  = cur.kind;
                    if (cur.len_left == 2'd0) begin
                        if (!data_byte[7]) begin
                            nxt.len  = LEN_W'(n_bytes);
                            finished = 1'b1;
                        end else if (n_bytes > 7'(LEN_BYTES_MAX)) begin
                            res.status = ST_LONG_LEN;
                            nxt.skip   = 1'b1;
                        end else if (n_bytes == 7'd0) begin
                            nxt.len  = '0;
                            finished = 1'b1;
                        end else begin
                            nxt.len_left = n_bytes[1:0];
                            nxt.len      = '0;
                            pending      = 1'b1;
                        end
                    end else begin
                        nxt.len      = {cur.len[LEN_W-9:0], data_byte};
                        nxt.len_left = cur.len_left - 2'd1;
                        if (cur.len_left == 2'd1) begin
                            finished = 1'b1;
                        end else begin
                            pending = 1'b1;
                        end
                    end
                    res.vlen = nxt.len;
                    if (finished) begin
                        if (nxt.len == '0) begin
                            res.done   = 1'b1;
                            res.status = elem_status(cur.kind, '0, cur.digit_err,
                                                     cur.char_err, cfg);
                        end else begin
                            nxt.phase   = PH_VAL;
                            nxt.val_cnt = '0;
                            pending     = 1'b1;
                        end
                    end
                end
                PH_VAL: begin
                    res.role  = ROLE_VAL;
                    res.tag   = cur.tag;
                    res.known = 1'b1;
                    res.kind  = cur.kind;
                    res.vlen  = cur.len;
                    res.vidx  = cur.val_cnt;
                    if (cur.kind == KIND_PAN && !is_bcd(data_byte)) begin
                        nxt.digit_err = 1'b1;
                    end
                    if (cur.kind == KIND_ISSUER && cur.val_cnt < LEN_W'(2)
                        && !is_bcd(data_byte)) begin
                        nxt.digit_err = 1'b1;
                    end
                    if (cur.kind == KIND_NAME
                        && (data_byte < PRINT_LO || data_byte > PRINT_HI)) begin
                        nxt.char_err = 1'b1;
                    end
                    nxt.val_cnt = cnt_ext[LEN_W-1:0];
                    if (cnt_ext >= {1'b0, cur.len}) begin
                        res.done   = 1'b1;
                        res.status = elem_status(cur.kind, cur.len, nxt.digit_err,
                                                 nxt.char_err, cfg);
                    end else begin
                        pending = 1'b1;
                    end
                end
                default: nxt = cur;
            endcase
        end

        if (eor && pending && res.status == ST_OK) begin
            res.status = ST_TRUNC;
        end

        if (res.done || eor) begin
            skip_keep = nxt.skip;
            nxt       = STATE_CLEAR;
            nxt.skip  = eor ? 1'b0 : skip_keep;
        end
    end

endmodule

FILE: design/emv_tlv_stream_parser.sv
`timescale 1ns / 1ps
// Each result passes through the input register, then the result register;
// both hold their contents while the output is stalled.
// Throughput: one byte per cycle; the result register frees the input side
// whenever it is empty or being taken in the same cycle.
// Reset (aresetn low, synchronous): parse state cleared, skipping off,
// limit registers back to their defaults, both channels empty.

module emv_tlv_stream_parser (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [emvtlv_pkg::BYTE_W-1:0]         s_tdata,  // data_byte
    input  logic                                  s_tlast,  // end_of_record
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tag_so_far, tag_known, value_length, value_index, element_done, status, zero fill
    output logic [emvtlv_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [emvtlv_pkg::OUT_TUSER_W-1:0]    m_tuser,  // byte_role, element_kind
    output logic                                  m_tlast,  // record_done
    input  logic                                  cfg_we,
    input  logic [emvtlv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [emvtlv_pkg::CFG_W-1:0]          cfg_wdata
);
    import emvtlv_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;
    state_t            state_reg;
    state_t            state_next;
    cfg_t              cfg_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;
    logic              advance;
    logic              fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    emvtlv_step u_step (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .data_byte (in_data_reg),
        .eor       (in_last_reg),
        .nxt       (state_next),
        .res       (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PAN_MIN:  cfg_reg.pan_min  <= cfg_wdata;
                CFG_PAN_MAX:  cfg_reg.pan_max  <= cfg_wdata;
                CFG_NAME_MIN: cfg_reg.name_min <= cfg_wdata;
                CFG_NAME_MAX: cfg_reg.name_max <= cfg_wdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.status, out_reg.done, out_reg.vidx, out_reg.vlen,
                       out_reg.known, out_reg.tag};
    assign m_tuser  = {out_reg.kind, out_reg.role};
    assign m_tlast  = out_reg.last;

    a_eor_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> state_reg.phase == PH_TAG && !state_reg.skip
                                && state_reg.tag_cnt == 2'd0)
        else $error("parse state not cleared after end of record");

    a_done_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.done |-> out_reg.role == ROLE_LEN || out_reg.role == ROLE_VAL)
        else $error("element end on a tag or skipped byte");

    a_skip_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.role == ROLE_SKIP |-> out_reg.status == ST_OK && !out_reg.done
                                               && !out_reg.known)
        else $error("skipped byte carries element fields");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a byte under backpressure");

endmodule
